### sv/sba_pkg.sv
// Shared types, constants and helper functions for the sector bitmap allocator.
// No dependencies; the allocator and the summary import this package.
package sba_pkg;

    // Map geometry
    localparam int MAP_SECTORS = 4096;
    localparam int WORD_BITS   = 32;
    localparam int MAP_WORDS   = (MAP_SECTORS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_IDX_W  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_IDX_W   = $clog2(WORD_BITS);

    // Field widths
    localparam int SECTOR_W = 12;
    localparam int LIMIT_W  = 13;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd32;

    localparam logic [WORD_BITS-1:0] ALL_FREE  = 32'hFFFF_FFFF;
    localparam logic [WORD_BITS-1:0] ALL_TAKEN = 32'h0000_0000;

    typedef enum logic [1:0] {
        CMD_FORMAT  = 2'd0,
        CMD_ALLOC   = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_RESERVE = 2'd3
    } cmd_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MODIFY,
        ST_RESP
    } state_t;

    typedef struct packed {
        cmd_e                command;
        logic [SECTOR_W-1:0] sector;
    } in_beat_t;

    typedef struct packed {
        logic [SECTOR_W-1:0] granted_sector;
        logic                status;
    } out_beat_t;

    // Control from the sequencer to the summary/valid tracker
    typedef struct packed {
        logic                  format;
        logic [LIMIT_W-1:0]    limit;
        logic                  upd;
        logic [WORD_IDX_W-1:0] upd_idx;
        logic                  upd_nonzero;
    } sum_ctrl_t;

    // Status from the tracker back to the sequencer
    typedef struct packed {
        logic                  any_free;
        logic [WORD_IDX_W-1:0] low_idx;
        logic                  q_valid;
        logic [WORD_BITS-1:0]  q_fmt_word;
    } sum_stat_t;

    // Bits of a word that stand for real sectors
    function automatic logic [WORD_BITS-1:0] valid_mask(input logic [WORD_IDX_W-1:0] w);
        logic [31:0] first;
        logic [31:0] left;
        first = 32'(w) << BIT_IDX_W;
        left  = 32'(MAP_SECTORS) - first;
        if (left >= 32'(WORD_BITS))
            return ALL_FREE;
        return (32'(1) << left[BIT_IDX_W-1:0]) - 32'(1);
    endfunction

    // Content of word w right after a format with the given limit
    function automatic logic [WORD_BITS-1:0] fmt_word(input logic [WORD_IDX_W-1:0] w,
                                                      input logic [LIMIT_W-1:0]    limit);
        logic [31:0] first;
        first = 32'(w) << BIT_IDX_W;
        if (first < 32'(limit))
            return ALL_TAKEN;
        return ALL_FREE & valid_mask(w);
    endfunction

    // Index of the lowest set bit of a word (0 when empty)
    function automatic logic [BIT_IDX_W-1:0] low_bit(input logic [WORD_BITS-1:0] x);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (x[i])
                idx = BIT_IDX_W'(i);
        end
        return idx;
    endfunction

endpackage

### sv/sector_bitmap_allocator.sv
// Sector bitmap allocator: sequencer, configuration register and output stage.
// Output beat: format, full-map allocate and out-of-range release or reserve go
// straight to respond; allocate, release and reserve in range go through modify
// (map RAM read-modify-write), then respond. One command at a time: the
// input is stalled until the reply beat is registered.
// Reset: map reads as formatted with limit 32 at once (written flags cleared);
// no clearing pass.
module sector_bitmap_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  sba_pkg::in_beat_t           in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output sba_pkg::out_beat_t          out_data,
    input  logic                        cfg_we,
    input  logic [sba_pkg::LIMIT_W-1:0] cfg_data
);
    import sba_pkg::*;

    state_t                state_reg, state_next;
    cmd_e                  cmd_reg, cmd_next;
    logic [WORD_IDX_W-1:0] word_reg, word_next;
    logic [BIT_IDX_W-1:0]  bit_reg, bit_next;
    out_beat_t             res_reg, res_next;
    out_beat_t             out_reg;
    logic                  out_valid_reg;
    logic [LIMIT_W-1:0]    limit_reg;

    logic                  in_acc;
    logic                  out_free;
    logic                  in_range;
    logic [31:0]           sec32;
    logic [WORD_IDX_W-1:0] sec_word;
    logic [WORD_BITS-1:0]  cur_word;
    logic [WORD_BITS-1:0]  new_word;
    logic [BIT_IDX_W-1:0]  mod_bit;
    logic [WORD_IDX_W-1:0] rd_addr;
    logic                  ram_we;
    logic [WORD_BITS-1:0]  ram_rdata;
    sum_ctrl_t             sum_ctrl;
    sum_stat_t             sum_stat;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign sec32    = 32'(in_data.sector);
    assign sec_word = sec32[BIT_IDX_W +: WORD_IDX_W];
    assign in_range = sec32 < 32'(MAP_SECTORS);

    // Word as it stands: RAM data once written, format value before
    assign cur_word = sum_stat.q_valid ? ram_rdata : sum_stat.q_fmt_word;
    assign mod_bit  = (cmd_reg == CMD_ALLOC) ? low_bit(cur_word) : bit_reg;

    always_comb
    begin
        if (cmd_reg == CMD_RELEASE)
            new_word = cur_word | (32'(1) << mod_bit);
        else
            new_word = cur_word & ~(32'(1) << mod_bit);
    end

    sba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS),
        .ADDR_W(WORD_IDX_W)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .waddr(word_reg),
        .wdata(new_word),
        .raddr(rd_addr),
        .rdata(ram_rdata)
    );

    sba_summary u_summary (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (sum_ctrl),
        .q_idx(word_reg),
        .stat (sum_stat)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (in_data.command)
                        CMD_FORMAT:  state_next = ST_RESP;
                        CMD_ALLOC:   state_next = sum_stat.any_free ? ST_MODIFY : ST_RESP;
                        CMD_RELEASE,
                        CMD_RESERVE: state_next = in_range ? ST_MODIFY : ST_RESP;
                        default:     state_next = ST_RESP;
                    endcase
                end
            end
            ST_MODIFY: state_next = ST_RESP;
            ST_RESP:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath controls
    always_comb
    begin
        cmd_next             = cmd_reg;
        word_next            = word_reg;
        bit_next             = bit_reg;
        res_next             = res_reg;
        rd_addr              = word_reg;
        ram_we               = 1'b0;
        sum_ctrl.format      = 1'b0;
        sum_ctrl.limit       = limit_reg;
        sum_ctrl.upd         = 1'b0;
        sum_ctrl.upd_idx     = word_reg;
        sum_ctrl.upd_nonzero = (new_word != ALL_TAKEN);
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_addr = (in_data.command == CMD_ALLOC) ? sum_stat.low_idx : sec_word;
                if (in_acc)
                begin
                    cmd_next  = in_data.command;
                    word_next = rd_addr;
                    bit_next  = in_data.sector[BIT_IDX_W-1:0];
                    res_next  = '0;
                    if (in_data.command == CMD_FORMAT)
                        sum_ctrl.format = 1'b1;
                    else if (in_data.command == CMD_ALLOC && !sum_stat.any_free)
                        res_next.status = 1'b1;
                end
            end
            ST_MODIFY:
            begin
                ram_we       = 1'b1;
                sum_ctrl.upd = 1'b1;
                if (cmd_reg == CMD_ALLOC)
                    res_next.granted_sector = SECTOR_W'({word_reg, mod_bit});
            end
            ST_RESP: ;
            default: ;
        endcase
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        word_reg <= word_next;
        bit_reg  <= bit_next;
        res_reg  <= res_next;
    end

    // Reserved limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_we)
            limit_reg <= cfg_data;
    end

    // Output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_RESP && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RESP && out_free)
            out_reg <= res_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Modify only follows an accepted beat
    a_modify_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MODIFY |-> $past(in_acc))
        else $error("modify without accepted beat");

    // An accepted beat always leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg != ST_IDLE)
        else $error("accepted beat did not start work");

    // A new output beat comes only from the respond state
    a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_RESP)
        else $error("output beat without response");

    // Summary said this word has a free sector
    a_alloc_word_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MODIFY && cmd_reg == CMD_ALLOC) |-> cur_word != ALL_TAKEN)
        else $error("allocate picked a full word");

endmodule

### sv/sba_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
module sba_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/sba_summary.sv
// Per-word summary (word has a free sector) and per-word written flags.
// Depends on sba_pkg; an unwritten word reads as its format value.
module sba_summary (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sba_pkg::sum_ctrl_t            ctrl,
    input  logic [sba_pkg::WORD_IDX_W-1:0] q_idx,
    output sba_pkg::sum_stat_t            stat
);
    import sba_pkg::*;

    logic [MAP_WORDS-1:0]  summary_reg;
    logic [MAP_WORDS-1:0]  written_reg;
    logic [LIMIT_W-1:0]    fmt_limit_reg;
    logic [WORD_IDX_W-1:0] low_idx;

    // Format resets all words to the pattern of the latched limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_limit_reg <= LIMIT_RESET;
            written_reg   <= '0;
            for (int i = 0; i < MAP_WORDS; i++)
                summary_reg[i] <= (fmt_word(WORD_IDX_W'(i), LIMIT_RESET) != ALL_TAKEN);
        end
        else if (ctrl.format)
        begin
            fmt_limit_reg <= ctrl.limit;
            written_reg   <= '0;
            for (int i = 0; i < MAP_WORDS; i++)
                summary_reg[i] <= (fmt_word(WORD_IDX_W'(i), ctrl.limit) != ALL_TAKEN);
        end
        else if (ctrl.upd)
        begin
            written_reg[ctrl.upd_idx] <= 1'b1;
            summary_reg[ctrl.upd_idx] <= ctrl.upd_nonzero;
        end
    end

    // Lowest word with a free sector
    always_comb
    begin
        low_idx = '0;
        for (int i = MAP_WORDS - 1; i >= 0; i--)
        begin
            if (summary_reg[i])
                low_idx = WORD_IDX_W'(i);
        end
    end

    assign stat.any_free   = |summary_reg;
    assign stat.low_idx    = low_idx;
    assign stat.q_valid    = written_reg[q_idx];
    assign stat.q_fmt_word = fmt_word(q_idx, fmt_limit_reg);

endmodule
